@@ rtl/swfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfr_pkg
// Shared types, constants and CRC-8 helpers for the stop-and-wait receiver.
// ----------------------------------------------------------------------------
package swfr_pkg;

  localparam int POS_W = 5;   // byte position, frames up to 18 bytes
  localparam int IDX_W = 4;   // payload entry index, up to 15 entries

  localparam logic [7:0] CRC_POLY   = 8'h31;
  localparam logic [5:0] MARKER     = 6'h1E;
  localparam logic [3:0] END_TYPE   = 4'hF;
  localparam logic [3:0] TYPE_ACK   = 4'h1;
  localparam logic [3:0] TYPE_NACK  = 4'h2;
  localparam logic [7:0] REPLY_HDR0 = {MARKER, 2'b00};
  localparam logic [1:0] SEQ_INIT   = 2'd1;
  localparam logic [7:0] HDR1_INIT  = {2'b00, SEQ_INIT, TYPE_NACK};

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef logic [3:0][7:0] crc_tab_t;

  // Everything the drain side needs about a finished frame.
  typedef struct packed {
    logic             ok;
    logic             endt;
    logic [3:0]       msg_type;
    logic [3:0]       length;
    logic [1:0]       seq;
    logic [7:0]       hdr1;
    logic [7:0]       crc;
    logic [IDX_W-1:0] count;
    logic             bank;
  } desc_t;

  // One byte of CRC-8, MSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
    end
    return r;
  endfunction

  // CRC of a reply frame: two header bytes, then zero bytes to frame length.
  function automatic logic [7:0] reply_crc(input logic [7:0] hdr1, input int frame_bytes);
    logic [7:0] c;
    c = crc8_byte(8'h00, REPLY_HDR0);
    c = crc8_byte(c, hdr1);
    for (int k = 0; k < frame_bytes - 2; k++) begin
      c = crc8_byte(c, 8'h00);
    end
    return c;
  endfunction

  // ACK reply CRC for each sequence value; evaluated at elaboration.
  function automatic crc_tab_t ack_crc_table(input int frame_bytes);
    crc_tab_t t;
    for (int s = 0; s < 4; s++) begin
      t[s] = reply_crc({2'b00, 2'(s), TYPE_ACK}, frame_bytes);
    end
    return t;
  endfunction

endpackage

@@ rtl/stop_and_wait_frame_receiver_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_and_wait_frame_receiver_core
// Stop-and-wait frame receiver: CRC-8 check, sequence tracking, payload
// drain from a two-bank payload RAM and one reply/status item per frame.
// ----------------------------------------------------------------------------
// Throughput: one input byte per cycle while in_stall is low, one result item
//   per cycle while out_stall is low. A frame's first result passes the RAM
//   read register, then the output register, after its last byte is taken.
// The input stalls only on a frame's last byte while the previous frame's
//   results (up to FRAME_BYTES-2 items) are still draining.
// Reset: clears control state; the payload RAM is not cleared (no sweep).
module stop_and_wait_frame_receiver_core #(
  parameter int FRAME_BYTES = 18   // 4 .. 18
) (
  input  logic       clk,
  input  logic       rst,
  // input bytes
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  // results
  output logic       out_valid,
  input  logic       out_stall,
  output logic       result_kind,
  output logic [7:0] payload_byte,
  output logic       accepted,
  output logic [3:0] msg_type,
  output logic [3:0] length,
  output logic [1:0] seq_field,
  output logic       end_transfer,
  output logic [7:0] reply_hdr0,
  output logic [7:0] reply_hdr1,
  output logic [7:0] reply_crc,
  output logic       last
);
  import swfr_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0] PAY_MAX  = IDX_W'(FRAME_BYTES - 3);
  localparam crc_tab_t         ACK_CRC  = ack_crc_table(FRAME_BYTES);
  localparam logic [7:0]       CRC_INIT = swfr_pkg::reply_crc(HDR1_INIT, FRAME_BYTES);

  // ---------------------------------------------------------------------
  // Receive side: byte counter, running CRC, header bytes
  // ---------------------------------------------------------------------
  logic [POS_W-1:0] byte_position;
  logic [7:0]       crc_acc;
  logic [7:0]       hdr_b0;
  logic [7:0]       hdr_b1;
  logic [1:0]       expected_seq;
  logic [7:0]       rep_hdr1;     // last reply header byte 1
  logic [7:0]       rep_crc;      // its CRC
  logic             wr_bank;      // RAM bank the current frame fills

  // Drain side
  desc_t            desc;
  logic             drain_active;
  logic [IDX_W-1:0] drain_idx;
  logic             p1_valid;     // RAM read / status slot in flight
  logic             p1_kind;
  logic             busy;

  logic             in_fire;
  logic [POS_W-1:0] pos_eff;
  logic [7:0]       crc_new;
  logic             frame_end;

  // Frame decode at the last byte
  logic [5:0]       f_mark;
  logic [3:0]       f_len;
  logic [1:0]       f_seq;
  logic [3:0]       f_type;
  logic             f_ok;
  logic             f_endt;
  logic [1:0]       seq_next;
  logic [IDX_W-1:0] f_count;
  logic [7:0]       ack_hdr1;

  // The last byte of a frame waits until the previous frame is fully drained,
  // so the descriptor and the RAM bank it reads are never overwritten early.
  assign busy     = drain_active | p1_valid;
  assign in_stall = (byte_position == LAST_POS) & busy;
  assign in_fire  = in_valid & ~in_stall;

  assign pos_eff   = frame_start ? '0 : byte_position;
  assign crc_new   = crc8_byte((pos_eff == '0) ? 8'h00 : crc_acc, rx_byte);
  assign frame_end = in_fire & (pos_eff == LAST_POS);

  assign f_mark   = hdr_b0[7:2];
  assign f_len    = {hdr_b0[1:0], hdr_b1[7:6]};
  assign f_seq    = hdr_b1[5:4];
  assign f_type   = hdr_b1[3:0];
  assign f_ok     = (f_mark == MARKER) & (f_seq == expected_seq) & (crc_new == 8'h00);
  assign seq_next = f_ok ? 2'(expected_seq + 2'd1) : expected_seq;
  // End of transfer: end type whose sequence is the one just before the
  // (updated) expected count, i.e. the end frame was accepted now or earlier.
  assign f_endt   = (f_mark == MARKER) & (f_type == END_TYPE) &
                    (f_seq == 2'(seq_next - 2'd1));
  assign ack_hdr1 = {2'b00, expected_seq, TYPE_ACK};

  always_comb begin
    if (!f_ok || f_type == END_TYPE) begin
      f_count = '0;
    end else if (f_len > PAY_MAX) begin
      f_count = PAY_MAX;
    end else begin
      f_count = f_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      crc_acc       <= 8'h00;
      expected_seq  <= SEQ_INIT;
      rep_hdr1      <= HDR1_INIT;
      rep_crc       <= CRC_INIT;
      wr_bank       <= 1'b0;
    end else if (in_fire) begin
      crc_acc <= crc_new;
      if (frame_end) begin
        byte_position <= '0;
        expected_seq  <= seq_next;
        wr_bank       <= ~wr_bank;
        if (f_ok) begin
          rep_hdr1 <= ack_hdr1;
          rep_crc  <= ACK_CRC[expected_seq];
        end
      end else begin
        byte_position <= POS_W'(pos_eff + 1'b1);
      end
    end
  end

  // Header bytes
  always_ff @(posedge clk) begin
    if (in_fire && pos_eff == POS_W'(0)) begin
      hdr_b0 <= rx_byte;
    end
    if (in_fire && pos_eff == POS_W'(1)) begin
      hdr_b1 <= rx_byte;
    end
  end

  // Frame descriptor, taken at the frame's last byte
  always_ff @(posedge clk) begin
    if (frame_end) begin
      desc.ok       <= f_ok;
      desc.endt     <= f_endt;
      desc.msg_type <= f_type;
      desc.length   <= f_len;
      desc.seq      <= f_seq;
      desc.hdr1     <= f_ok ? ack_hdr1 : rep_hdr1;
      desc.crc      <= f_ok ? ACK_CRC[expected_seq] : rep_crc;
      desc.count    <= f_count;
      desc.bank     <= wr_bank;
    end
  end

  // ---------------------------------------------------------------------
  // Payload RAM: two banks of 16 entries, one write and one read port
  // ---------------------------------------------------------------------
  logic [7:0]       pay_mem [2**(IDX_W+1)];
  logic             mem_we;
  logic [IDX_W:0]   mem_waddr;
  logic             mem_re;
  logic [IDX_W:0]   mem_raddr;
  logic [7:0]       rd_data;

  assign mem_we    = in_fire & (pos_eff >= POS_W'(2)) & (pos_eff < LAST_POS);
  assign mem_waddr = {wr_bank, IDX_W'(pos_eff - POS_W'(2))};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pay_mem[mem_waddr] <= rx_byte;
    end
    if (mem_re) begin
      rd_data <= pay_mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------
  // Drain: issue payload reads, then one status slot; output register
  // ---------------------------------------------------------------------
  logic out_free;
  logic issue_ok;
  logic issue;
  logic issue_payload;

  assign out_free      = ~out_valid | ~out_stall;
  // A new slot may enter stage 1 only if stage 1 is empty or drains into the output.
  assign issue_ok      = ~p1_valid | out_free;
  assign issue         = drain_active & issue_ok;
  assign issue_payload = issue & (drain_idx != desc.count);
  assign mem_re        = issue_payload;
  assign mem_raddr     = {desc.bank, drain_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      drain_active <= 1'b0;
      drain_idx    <= '0;
      p1_valid     <= 1'b0;
    end else begin
      if (frame_end) begin
        drain_active <= 1'b1;
        drain_idx    <= '0;
      end else if (issue) begin
        if (issue_payload) begin
          drain_idx <= IDX_W'(drain_idx + 1'b1);
        end else begin
          drain_active <= 1'b0;
        end
      end
      if (issue) begin
        p1_valid <= 1'b1;
      end else if (out_free) begin
        p1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p1_kind <= issue_payload ? KIND_PAYLOAD : KIND_STATUS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && p1_valid) begin
      result_kind <= p1_kind;
      msg_type    <= desc.msg_type;
      length      <= desc.length;
      seq_field   <= desc.seq;
      if (p1_kind == KIND_PAYLOAD) begin
        payload_byte <= rd_data;
        accepted     <= 1'b1;
        end_transfer <= 1'b0;
        reply_hdr0   <= 8'h00;
        reply_hdr1   <= 8'h00;
        reply_crc    <= 8'h00;
        last         <= 1'b0;
      end else begin
        payload_byte <= 8'h00;
        accepted     <= desc.ok;
        end_transfer <= desc.endt;
        reply_hdr0   <= REPLY_HDR0;
        reply_hdr1   <= desc.hdr1;
        reply_crc    <= desc.crc;
        last         <= 1'b1;
      end
    end
  end

endmodule

@@ verif/stop_and_wait_frame_receiver_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_and_wait_frame_receiver_core_tb
// Self-checking bench for the stop-and-wait frame receiver. A table of
// directed frames comes first: reset reply, duplicate, bad CRC, bad marker,
// restart mid-frame, back-to-back frames and end frames. Random frames follow,
// mostly well formed with random content, mixed with broken frames and noise.
// An in-bench frame predictor queues expected items, and every output item is
// compared field by field. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module stop_and_wait_frame_receiver_core_tb;
  import swfr_pkg::*;

  localparam int FRAME_LEN  = 18;
  localparam int RAND_BYTES = 125;
  localparam int QUIET_FROM = 95;      // no idling after this many random bytes
  localparam int CYCLE_CAP  = 100000;

  typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_ALT, FILL_RAND} fill_t;

  // One output item as seen on the result ports.
  typedef struct {
    logic       kind;
    logic [7:0] pbyte;
    logic       ok;
    logic [3:0] ty;
    logic [3:0] ln;
    logic [1:0] sq;
    logic       endt;
    logic [7:0] h0;
    logic [7:0] h1;
    logic [7:0] crc;
    logic       lst;
  } frame_res_t;

  // Directed frame: header fields, fill, CRC corruption, start flag, bytes
  // sent (short = cut off), and hand-typed status fields where chk is set.
  typedef struct {
    logic [5:0] mk;
    logic [3:0] ln;
    logic [1:0] sq;
    logic [3:0] ty;
    fill_t      fill;
    logic       bad;
    logic       st;
    int         nb;
    logic       chk;
    logic       ok;
    logic [7:0] h1;
    logic       endt;
  } dir_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       frame_start = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       result_kind;
  logic [7:0] payload_byte;
  logic       accepted;
  logic [3:0] msg_type;
  logic [3:0] length;
  logic [1:0] seq_field;
  logic       end_transfer;
  logic [7:0] reply_hdr0;
  logic [7:0] reply_hdr1;
  logic [7:0] reply_crc;
  logic       last;

  // Hand-typed status fields ride along with the item they belong to.
  logic       tag_chk = 1'b0;
  logic       tag_ok = 1'b0;
  logic [7:0] tag_h1 = 8'h00;
  logic       tag_endt = 1'b0;

  // Predictor state.
  logic [4:0] pos_q;
  logic [7:0] hdr_q [2];
  logic [7:0] pay_q [FRAME_LEN-3];
  logic [7:0] crc_q;
  logic [1:0] next_seq_q;
  logic [15:0] reply_q;

  frame_res_t pending_results [$];

  logic [7:0] frm [FRAME_LEN];
  dir_row_t   dir_tab [11];
  logic [1:0] drv_seq;
  logic       aligned;
  logic       in_idle_en;
  logic       stall_en;
  int         stall_left;
  int         rand_bytes;
  int         mismatch_cnt;
  int         cycles;
  int         status_seen;
  int         acc_seen;
  int         payload_seen;

  stop_and_wait_frame_receiver_core #(
    .FRAME_BYTES(FRAME_LEN)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .frame_start  (frame_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .payload_byte (payload_byte),
    .accepted     (accepted),
    .msg_type     (msg_type),
    .length       (length),
    .seq_field    (seq_field),
    .end_transfer (end_transfer),
    .reply_hdr0   (reply_hdr0),
    .reply_hdr1   (reply_hdr1),
    .reply_crc    (reply_crc),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // CRC-8, poly 0x31, MSB first, one bit per pass.
  function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[7] ^ b[k];
      r  = {r[6:0], 1'b0};
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  // CRC of a reply frame: header then zero bytes out to frame length.
  function automatic logic [7:0] reply_frame_crc(input logic [15:0] hdr);
    logic [7:0] c;
    c = crc_step(8'h00, hdr[15:8]);
    c = crc_step(c, hdr[7:0]);
    for (int k = 0; k < FRAME_LEN - 2; k++) c = crc_step(c, 8'h00);
    return c;
  endfunction

  task automatic clear_predictor();
    pos_q      = '0;
    crc_q      = 8'h00;
    next_seq_q = SEQ_INIT;
    reply_q    = {REPLY_HDR0, HDR1_INIT};
    hdr_q[0]   = 8'h00;
    hdr_q[1]   = 8'h00;
    for (int k = 0; k < FRAME_LEN - 3; k++) pay_q[k] = 8'h00;
  endtask

  // Frame predictor: one accepted byte in, expected items queued.
  task automatic predict_rx_byte(input logic [7:0] b, input logic s, input logic tchk,
                                 input logic tok, input logic [7:0] th1, input logic tendt);
    logic [4:0] pos;
    logic [5:0] mk;
    logic [3:0] ln;
    logic [3:0] ty;
    logic [1:0] sq;
    logic       ok;
    int         cnt;
    frame_res_t r;
    if (s) begin
      pos_q = '0;
      crc_q = 8'h00;
    end
    pos = pos_q;
    if (pos == 0) crc_q = 8'h00;
    crc_q = crc_step(crc_q, b);
    if (pos < 2) hdr_q[pos[0]] = b;
    else if (pos < FRAME_LEN - 1) pay_q[4'(pos - 5'd2)] = b;
    if (pos + 1 < FRAME_LEN) begin
      pos_q = 5'(pos + 5'd1);
      return;
    end
    pos_q = '0;

    mk = hdr_q[0][7:2];
    ln = {hdr_q[0][1:0], hdr_q[1][7:6]};
    sq = hdr_q[1][5:4];
    ty = hdr_q[1][3:0];
    ok = (mk == MARKER) && (sq == next_seq_q) && (crc_q == 8'h00);

    if (ok) begin
      if (ty != END_TYPE) begin
        cnt = (ln > FRAME_LEN - 3) ? FRAME_LEN - 3 : ln;
        for (int k = 0; k < cnt; k++) begin
          r = '{KIND_PAYLOAD, pay_q[k], 1'b1, ty, ln, sq, 1'b0,
                8'h00, 8'h00, 8'h00, 1'b0};
          pending_results.push_back(r);
        end
      end
      reply_q    = {REPLY_HDR0, 2'b00, next_seq_q, TYPE_ACK};
      next_seq_q = next_seq_q + 2'd1;
    end

    r = '{KIND_STATUS, 8'h00, ok, ty, ln, sq,
          (mk == MARKER) && (ty == END_TYPE) && (sq == next_seq_q - 2'd1),
          reply_q[15:8], reply_q[7:0], reply_frame_crc(reply_q), 1'b1};
    // Directed rows with typed status fields override the prediction.
    if (tchk) begin
      r.ok   = tok;
      r.h1   = th1;
      r.endt = tendt;
    end
    pending_results.push_back(r);
  endtask

  task automatic cmp_field(input string nm, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, nm, want, got);
    end
  endtask

  // Output check first, then prediction.
  always @(posedge clk) begin : monitor
    frame_res_t e;
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout, %0d items still pending", $time, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end else if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected item, expected none, actual kind %0d byte %0h",
                   $time, result_kind, payload_byte);
        end else begin
          e = pending_results.pop_front();
          cmp_field("result_kind", e.kind, result_kind);
          cmp_field("payload_byte", e.pbyte, payload_byte);
          cmp_field("accepted", e.ok, accepted);
          cmp_field("msg_type", e.ty, msg_type);
          cmp_field("length", e.ln, length);
          cmp_field("seq_field", e.sq, seq_field);
          cmp_field("end_transfer", e.endt, end_transfer);
          cmp_field("reply_hdr0", e.h0, reply_hdr0);
          cmp_field("reply_hdr1", e.h1, reply_hdr1);
          cmp_field("reply_crc", e.crc, reply_crc);
          cmp_field("last", e.lst, last);
          if (e.kind == KIND_STATUS) begin
            status_seen++;
            if (e.ok) acc_seen++;
          end else begin
            payload_seen++;
          end
        end
      end
      if (in_valid && !in_stall)
        predict_rx_byte(rx_byte, frame_start, tag_chk, tag_ok, tag_h1, tag_endt);
    end
  end

  // Back-end stall: random bursts while enabled.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // One item: optional idle burst, then hold until the edge that takes it.
  task automatic send_item(input logic [7:0] b, input logic s, input logic chk,
                           input logic ok, input logic [7:0] h1, input logic endt);
    if (in_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    rx_byte     <= b;
    frame_start <= s;
    tag_chk     <= chk;
    tag_ok      <= ok;
    tag_h1      <= h1;
    tag_endt    <= endt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic build_frame(input logic [5:0] mk, input logic [3:0] ln, input logic [1:0] sq,
                             input logic [3:0] ty, input fill_t fill, input logic bad);
    logic [7:0] c;
    frm[0] = {mk, ln[3:2]};
    frm[1] = {ln[1:0], sq, ty};
    for (int k = 2; k < FRAME_LEN - 1; k++) begin
      case (fill)
        FILL_ZERO: frm[k] = 8'h00;
        FILL_ONES: frm[k] = 8'hFF;
        FILL_ALT:  frm[k] = k[0] ? 8'h55 : 8'hAA;
        default:   frm[k] = 8'($urandom_range(0, 255));
      endcase
    end
    c = 8'h00;
    for (int k = 0; k < FRAME_LEN - 1; k++) c = crc_step(c, frm[k]);
    if (bad) c = c ^ 8'(1 << $urandom_range(0, 7));
    frm[FRAME_LEN-1] = c;
  endtask

  // Sends the first nb bytes of frm; typed fields go with the last byte.
  task automatic send_frame(input logic st, input int nb, input logic chk, input logic ok,
                            input logic [7:0] h1, input logic endt);
    for (int k = 0; k < nb; k++)
      send_item(frm[k], (k == 0) ? st : 1'b0, chk && (k == FRAME_LEN - 1), ok, h1, endt);
    rand_bytes += nb;
  endtask

  // Sender holds off until every queued item has drained.
  task automatic drain_wait();
    in_valid <= 1'b0;
    tag_chk  <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    drv_seq = next_seq_q;
  endtask

  task automatic random_frame();
    int         sel;
    int         nb;
    logic [3:0] ty;
    logic [3:0] ln;
    logic [5:0] mk;
    logic       st;
    sel = $urandom_range(0, 99);
    ty  = ($urandom_range(0, 9) == 0) ? END_TYPE : 4'($urandom_range(0, 15));
    ln  = 4'($urandom_range(0, 15));
    st  = aligned ? 1'($urandom_range(0, 1)) : 1'b1;
    if (sel < 64) begin
      build_frame(MARKER, ln, drv_seq, ty, FILL_RAND, 1'b0);
      send_frame(st, FRAME_LEN, 1'b0, 1'b0, 8'h00, 1'b0);
      drv_seq = drv_seq + 2'd1;
      aligned = 1'b1;
    end else if (sel < 72) begin
      build_frame(MARKER, ln, drv_seq + 2'($urandom_range(1, 3)), ty, FILL_RAND, 1'b0);
      send_frame(st, FRAME_LEN, 1'b0, 1'b0, 8'h00, 1'b0);
      aligned = 1'b1;
    end else if (sel < 80) begin
      build_frame(MARKER, ln, drv_seq, ty, FILL_RAND, 1'b1);
      send_frame(st, FRAME_LEN, 1'b0, 1'b0, 8'h00, 1'b0);
      aligned = 1'b1;
    end else if (sel < 86) begin
      mk = 6'($urandom_range(0, 63));
      if (mk == MARKER) mk = mk ^ 6'h01;
      build_frame(mk, ln, drv_seq, ty, FILL_RAND, 1'b0);
      send_frame(st, FRAME_LEN, 1'b0, 1'b0, 8'h00, 1'b0);
      aligned = 1'b1;
    end else if (sel < 94) begin
      // cut short; the next frame restarts with frame_start
      build_frame(MARKER, ln, drv_seq, ty, FILL_RAND, 1'b0);
      send_frame(st, $urandom_range(1, FRAME_LEN - 1), 1'b0, 1'b0, 8'h00, 1'b0);
      aligned = 1'b0;
    end else begin
      nb = $urandom_range(1, 20);
      for (int k = 0; k < nb; k++)
        send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                  1'b0, 1'b0, 8'h00, 1'b0);
      rand_bytes += nb;
      aligned = 1'b0;
    end
  endtask

  initial begin
    cycles       = 0;
    mismatch_cnt = 0;
    status_seen  = 0;
    acc_seen     = 0;
    payload_seen = 0;
    rand_bytes   = 0;
    stall_left   = 0;
    in_idle_en   = 1'b1;
    stall_en     = 1'b1;
    clear_predictor();

    //            mk       ln     sq     ty     fill       bad   st    nb
    //            chk   ok    typed reply hdr1             endt
    dir_tab = '{
      // rejected before any ACK: reset NACK reply
      '{MARKER, 4'd4,  2'd0, 4'h5, FILL_RAND, 1'b0, 1'b1, FRAME_LEN,
        1'b1, 1'b0, {2'b00, 2'd1, TYPE_NACK}, 1'b0},
      // back-to-back, no frame_start, longest payload of all ones
      '{MARKER, 4'd15, 2'd1, 4'h3, FILL_ONES, 1'b0, 1'b0, FRAME_LEN,
        1'b1, 1'b1, {2'b00, 2'd1, TYPE_ACK},  1'b0},
      // duplicate gets the last reply again
      '{MARKER, 4'd2,  2'd1, 4'h7, FILL_RAND, 1'b0, 1'b1, FRAME_LEN,
        1'b1, 1'b0, {2'b00, 2'd1, TYPE_ACK},  1'b0},
      // bad CRC
      '{MARKER, 4'd3,  2'd2, 4'h4, FILL_RAND, 1'b1, 1'b1, FRAME_LEN,
        1'b1, 1'b0, {2'b00, 2'd1, TYPE_ACK},  1'b0},
      // bad marker, all marker bits high
      '{6'h3F,  4'd5,  2'd2, 4'h6, FILL_RAND, 1'b0, 1'b1, FRAME_LEN,
        1'b1, 1'b0, {2'b00, 2'd1, TYPE_ACK},  1'b0},
      // partial frame, dropped by the restart below
      '{MARKER, 4'd9,  2'd2, 4'h2, FILL_RAND, 1'b0, 1'b1, 7,
        1'b0, 1'b0, 8'h00,                    1'b0},
      '{MARKER, 4'd0,  2'd2, 4'h0, FILL_ZERO, 1'b0, 1'b1, FRAME_LEN,
        1'b1, 1'b1, {2'b00, 2'd2, TYPE_ACK},  1'b0},
      '{MARKER, 4'd15, 2'd3, 4'hA, FILL_ALT,  1'b0, 1'b1, FRAME_LEN,
        1'b1, 1'b1, {2'b00, 2'd3, TYPE_ACK},  1'b0},
      // end frame: ACKed, no payload
      '{MARKER, 4'd9,  2'd0, END_TYPE, FILL_RAND, 1'b0, 1'b1, FRAME_LEN,
        1'b1, 1'b1, {2'b00, 2'd0, TYPE_ACK},  1'b1},
      // repeated end frame: rejected, still flags end of transfer
      '{MARKER, 4'd9,  2'd0, END_TYPE, FILL_RAND, 1'b0, 1'b1, FRAME_LEN,
        1'b1, 1'b0, {2'b00, 2'd0, TYPE_ACK},  1'b1},
      '{MARKER, 4'd1,  2'd1, 4'hC, FILL_RAND, 1'b0, 1'b0, FRAME_LEN,
        1'b1, 1'b1, {2'b00, 2'd1, TYPE_ACK},  1'b0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      build_frame(dir_tab[i].mk, dir_tab[i].ln, dir_tab[i].sq, dir_tab[i].ty,
                  dir_tab[i].fill, dir_tab[i].bad);
      send_frame(dir_tab[i].st, dir_tab[i].nb, dir_tab[i].chk, dir_tab[i].ok,
                 dir_tab[i].h1, dir_tab[i].endt);
    end
    drain_wait();

    // Random frames; idling per frame, none near the end.
    aligned    = 1'b1;
    rand_bytes = 0;
    while (rand_bytes < RAND_BYTES) begin
      if (rand_bytes >= QUIET_FROM) begin
        in_idle_en = 1'b0;
        stall_en   = 1'b0;
      end else begin
        in_idle_en = ($urandom_range(0, 3) != 0);
        stall_en   = ($urandom_range(0, 3) != 0);
      end
      random_frame();
      if (rand_bytes < QUIET_FROM && $urandom_range(0, 14) == 0) drain_wait();
    end

    in_valid <= 1'b0;
    tag_chk  <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d frame status items (%0d accepted) and %0d payload items",
             status_seen, acc_seen, payload_seen);
    $display("Stimulus: directed frame table, then %0d random bytes", rand_bytes);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d items never seen", mismatch_cnt,
               pending_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ stop_and_wait_frame_receiver_core.f @@
rtl/swfr_pkg.sv
rtl/stop_and_wait_frame_receiver_core.sv
verif/stop_and_wait_frame_receiver_core_tb.sv
